[src/mdc_pkg.sv]
// shared constants, types and the cosine weight table of the chorus
`default_nettype none
package mdc_pkg;
   localparam int RING_DEPTH        = 8192;
   localparam int COSINE_TABLE_SIZE = 1024;
   localparam int SAMPLE_BITS       = 24;
   localparam int PHASE_FRAC        = 22;
   localparam int RING_AW           = $clog2(RING_DEPTH);
   localparam int COS_AW            = $clog2(COSINE_TABLE_SIZE);
   localparam int PHASE_W           = COS_AW + PHASE_FRAC;
   localparam int WEIGHT_W          = 24;
   localparam int MUL_W             = 27;
   localparam int ACC_W             = 56;
   localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

   localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
   localparam logic [2:0] REG_BASE_OFFSET = 3'd1;
   localparam logic [2:0] REG_DEPTH_SPAN  = 3'd2;
   localparam logic [2:0] REG_DRY_GAIN    = 3'd3;
   localparam logic [2:0] REG_WET_GAIN    = 3'd4;
   localparam logic [2:0] REG_HP_B0       = 3'd5;
   localparam logic [2:0] REG_HP_A1       = 3'd6;
   localparam logic [2:0] REG_HP_A2       = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PHASE, ST_ROM, ST_DEPTH, ST_RDA, ST_RDB, ST_INT2, ST_DIFF,
      ST_F0, ST_F1, ST_F2, ST_YS, ST_M0, ST_M1, ST_OUT
   } state_type;

   typedef logic [WEIGHT_W-1:0] weight_lut_type [COSINE_TABLE_SIZE];

   // raised cosine weights in unsigned Q1.23, built at elaboration
   function automatic weight_lut_type weight_lut_build();
      weight_lut_type tbl;
      logic [63:0] m;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic signed [63:0] w;
      for (int i = 0; i < COSINE_TABLE_SIZE; i++) begin
         m = 64'(i);
         if (2 * i > COSINE_TABLE_SIZE) m = 64'(COSINE_TABLE_SIZE - i);
         t = (TWO_PI_Q28 * m) / COSINE_TABLE_SIZE;
         t2 = (t * t) >> 28;
         term = 64'd1 << 28;
         sum = signed'(term);
         for (int k = 1; k <= 12; k++) begin
            term = ((term * t2) >> 28) / 64'((2 * k - 1) * 2 * k);
            if (k % 2 == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
         end
         w = (64'sd1 <<< 28) + sum + 64'sd32;
         if (w < 0) w = 0;
         w = w >>> 6;
         if (w > (64'sd1 <<< 23)) w = 64'sd1 <<< 23;
         tbl[i] = WEIGHT_W'(w);
      end
      return tbl;
   endfunction

   localparam weight_lut_type WEIGHT_LUT = weight_lut_build();

   // clamp an accumulator value to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (v > hi) return SAMPLE_BITS'(hi);
      else if (v < lo) return SAMPLE_BITS'(lo);
      else return SAMPLE_BITS'(v);
   endfunction
endpackage
`default_nettype wire

[src/modulated_delay_chorus_top.sv]
// modulated delay chorus: ring delay line, cosine modulated tap, highpass and mix
// channel | ports                              | direction
// req     | req_valid, req_stall, req_sample_in | sample in
// rsp     | rsp_valid, rsp_stall, rsp_sample_out | mixed sample out
// csr     | csr_we, csr_index, csr_wdata       | register writes
// each item passes through the ring read-modify sequencer and the shared multiplier
// after reset all RING_DEPTH (8192) ring entries are cleared, no item is taken meanwhile
// the next item is taken while a result waits; a result stalls the sequencer only at its end
`default_nettype none
module modulated_delay_chorus_top (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [mdc_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [mdc_pkg::SAMPLE_BITS-1:0]       rsp_sample_out,
   input  wire logic                                    csr_we,
   input  wire logic [2:0]                              csr_index,
   input  wire logic [30:0]                             csr_wdata
);
   localparam int SB = mdc_pkg::SAMPLE_BITS;
   localparam int AW = mdc_pkg::RING_AW;
   localparam int MW = mdc_pkg::MUL_W;
   localparam int CW = mdc_pkg::ACC_W;

   logic [30:0]        phase_step_ff;
   logic [20:0]        base_offset_ff;
   logic [20:0]        depth_span_ff;
   logic [15:0]        dry_gain_ff;
   logic [15:0]        wet_gain_ff;
   logic signed [24:0] hp_b0_ff;
   logic signed [24:0] hp_a1_ff;
   logic signed [24:0] hp_a2_ff;

   mdc_pkg::state_type state_ff, state_in;
   logic               clear_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [AW-1:0]      wp_ff;
   logic [mdc_pkg::PHASE_W-1:0] phase_ff;
   logic [mdc_pkg::WEIGHT_W-1:0] weight_ff;
   logic [21:0]        fpos_ff;
   logic [AW-1:0]      addr_a_ff;
   logic signed [SB-1:0] x_ff, d_ff, y_ff;
   logic signed [SB-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [MW-1:0] e_ff;
   logic signed [CW-1:0] acc_ff;
   logic               rsp_valid_ff;
   logic signed [SB-1:0] rsp_data_ff;

   logic signed [SB-1:0] ring [mdc_pkg::RING_DEPTH];
   logic signed [SB-1:0] rdata_ff;
   logic [AW-1:0]      rd_addr;
   logic               ring_we;
   logic [AW-1:0]      ring_waddr;
   logic signed [SB-1:0] ring_wdata;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [2*MW-1:0] product;
   logic               acc_clr;
   logic signed [CW-1:0] acc_sum;
   logic signed [CW-1:0] y_round, mix_round;
   logic [AW-1:0]      addr_a;
   logic [AW-1:0]      addr_b;
   logic [8:0]         r_inv;
   logic               accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = clear_ff || (state_ff != mdc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   assign addr_a = AW'(32'(wp_ff) + 32'(fpos_ff >> 8));
   assign addr_b = AW'({1'b0, addr_a_ff} + 1'b1);
   assign r_inv  = 9'd256 - {1'b0, fpos_ff[7:0]};

   // ring memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ring_we) ring[ring_waddr] <= ring_wdata;
      rdata_ff <= ring[rd_addr];
   end

   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = wp_ff;
      ring_wdata = x_ff;
      if (clear_ff) begin
         ring_we    = 1'b1;
         ring_waddr = clr_addr_ff;
         ring_wdata = '0;
      end else if (state_ff == mdc_pkg::ST_PHASE) begin
         ring_we = 1'b1;
      end
      // first tap is read in ST_RDA, its neighbor in ST_RDB
      rd_addr = (state_ff == mdc_pkg::ST_RDB) ? addr_b : addr_a;
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      acc_clr = 1'b0;
      unique case (state_ff)
         mdc_pkg::ST_RDB: begin
            mul_a = MW'(rdata_ff); mul_b = MW'($signed({1'b0, r_inv})); acc_clr = 1'b1;
         end
         mdc_pkg::ST_INT2: begin
            mul_a = MW'(rdata_ff); mul_b = MW'($signed({1'b0, fpos_ff[7:0]}));
         end
         mdc_pkg::ST_F0: begin
            mul_a = MW'(hp_b0_ff); mul_b = e_ff; acc_clr = 1'b1;
         end
         mdc_pkg::ST_F1: begin
            mul_a = MW'(hp_a1_ff); mul_b = MW'(y1_ff);
         end
         mdc_pkg::ST_F2: begin
            mul_a = MW'(hp_a2_ff); mul_b = MW'(y2_ff);
         end
         mdc_pkg::ST_M0: begin
            mul_a = MW'($signed({1'b0, dry_gain_ff})); mul_b = MW'(x_ff); acc_clr = 1'b1;
         end
         mdc_pkg::ST_M1: begin
            mul_a = MW'($signed({1'b0, wet_gain_ff})); mul_b = MW'(y_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
      product = mul_a * mul_b;
      acc_sum = (acc_clr ? CW'(0) : acc_ff) + CW'(product);
      y_round   = (acc_ff + (CW'(1) <<< 21)) >>> 22;
      mix_round = (acc_ff + (CW'(1) <<< 13)) >>> 14;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdc_pkg::ST_IDLE:  if (accept) state_in = mdc_pkg::ST_PHASE;
         mdc_pkg::ST_PHASE: state_in = mdc_pkg::ST_ROM;
         mdc_pkg::ST_ROM:   state_in = mdc_pkg::ST_DEPTH;
         mdc_pkg::ST_DEPTH: state_in = mdc_pkg::ST_RDA;
         mdc_pkg::ST_RDA:   state_in = mdc_pkg::ST_RDB;
         mdc_pkg::ST_RDB:   state_in = mdc_pkg::ST_INT2;
         mdc_pkg::ST_INT2:  state_in = mdc_pkg::ST_DIFF;
         mdc_pkg::ST_DIFF:  state_in = mdc_pkg::ST_F0;
         mdc_pkg::ST_F0:    state_in = mdc_pkg::ST_F1;
         mdc_pkg::ST_F1:    state_in = mdc_pkg::ST_F2;
         mdc_pkg::ST_F2:    state_in = mdc_pkg::ST_YS;
         mdc_pkg::ST_YS:    state_in = mdc_pkg::ST_M0;
         mdc_pkg::ST_M0:    state_in = mdc_pkg::ST_M1;
         mdc_pkg::ST_M1:    state_in = mdc_pkg::ST_OUT;
         mdc_pkg::ST_OUT:   if (!rsp_valid_ff || !rsp_stall) state_in = mdc_pkg::ST_IDLE;
         default:           state_in = mdc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state, history and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clr_addr_ff    <= '0;
         wp_ff          <= '0;
         phase_ff       <= '0;
         x1_ff          <= '0;
         x2_ff          <= '0;
         y1_ff          <= '0;
         y2_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         phase_step_ff  <= '0;
         base_offset_ff <= '0;
         depth_span_ff  <= '0;
         dry_gain_ff    <= 16'd16384;
         wet_gain_ff    <= 16'd16384;
         hp_b0_ff       <= 25'sd4194304;
         hp_a1_ff       <= '0;
         hp_a2_ff       <= '0;
      end else begin
         if (clear_ff) begin
            clr_addr_ff <= AW'({1'b0, clr_addr_ff} + 1'b1);
            if (&clr_addr_ff) clear_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               mdc_pkg::REG_PHASE_STEP:  phase_step_ff  <= csr_wdata;
               mdc_pkg::REG_BASE_OFFSET: base_offset_ff <= csr_wdata[20:0];
               mdc_pkg::REG_DEPTH_SPAN:  depth_span_ff  <= csr_wdata[20:0];
               mdc_pkg::REG_DRY_GAIN:    dry_gain_ff    <= csr_wdata[15:0];
               mdc_pkg::REG_WET_GAIN:    wet_gain_ff    <= csr_wdata[15:0];
               mdc_pkg::REG_HP_B0:       hp_b0_ff       <= $signed(csr_wdata[24:0]);
               mdc_pkg::REG_HP_A1:       hp_a1_ff       <= $signed(csr_wdata[24:0]);
               mdc_pkg::REG_HP_A2:       hp_a2_ff       <= $signed(csr_wdata[24:0]);
               default:                  phase_step_ff  <= phase_step_ff;
            endcase
         end
         if (state_ff == mdc_pkg::ST_PHASE) begin
            wp_ff    <= AW'({1'b0, wp_ff} + 1'b1);
            phase_ff <= mdc_pkg::PHASE_W'(64'(phase_ff) + 64'(phase_step_ff));
         end
         if (state_ff == mdc_pkg::ST_YS) begin
            x2_ff <= x1_ff;
            x1_ff <= d_ff;
            y2_ff <= y1_ff;
            y1_ff <= mdc_pkg::sat_sample(y_round);
         end
         if (state_ff == mdc_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) x_ff <= req_sample_in;
      if (state_ff == mdc_pkg::ST_ROM) begin
         weight_ff <= mdc_pkg::WEIGHT_LUT[phase_ff[mdc_pkg::PHASE_W-1:mdc_pkg::PHASE_FRAC]];
      end
      if (state_ff == mdc_pkg::ST_DEPTH) begin
         fpos_ff <= 22'(base_offset_ff) + 22'((45'(depth_span_ff) * 45'(weight_ff)) >> 23);
      end
      if (state_ff == mdc_pkg::ST_RDA) addr_a_ff <= addr_a;
      if (acc_clr || state_ff == mdc_pkg::ST_INT2 || state_ff == mdc_pkg::ST_F1 ||
          state_ff == mdc_pkg::ST_F2 || state_ff == mdc_pkg::ST_M1) begin
         acc_ff <= acc_sum;
      end
      if (state_ff == mdc_pkg::ST_DIFF) begin
         d_ff <= SB'(acc_ff >>> 8);
         e_ff <= MW'(SB'(acc_ff >>> 8)) - (MW'(x1_ff) <<< 1) + MW'(x2_ff);
      end
      if (state_ff == mdc_pkg::ST_YS) y_ff <= mdc_pkg::sat_sample(y_round);
      if (state_ff == mdc_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff <= mdc_pkg::sat_sample(mix_round);
      end
   end

   // no item enters while the ring is cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> req_stall)
      else $error("item taken during ring clear");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == mdc_pkg::ST_PHASE)
      else $error("accepted item did not start the sequence");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !rsp_valid_ff && state_ff == mdc_pkg::ST_IDLE)
      else $error("result or work during ring clear");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdc_pkg::ST_OUT && rsp_valid_ff && rsp_stall) |=>
      state_ff == mdc_pkg::ST_OUT)
      else $error("result overwritten while stalled");
endmodule
`default_nettype wire
